/* rtl/fcsb_pkg.sv */
// Shared types and constants for the sphere and box frustum culler.
`timescale 1ns / 1ps
package fcsb_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int ROW_COUNT = 3;
  localparam int LAST_ROW_OP = 2;
  localparam int LAST_OP = 6;
  localparam int NORMAL_W = 18;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SPHERE = 2'd1,
    REQ_BOX    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [2:0] REG_NEAR   = 3'd0;
  localparam logic [2:0] REG_FAR    = 3'd1;
  localparam logic [2:0] REG_LEFT   = 3'd2;
  localparam logic [2:0] REG_TOP    = 3'd3;
  localparam logic [2:0] REG_RIGHT  = 3'd4;
  localparam logic [2:0] REG_BOTTOM = 3'd5;

  localparam logic [30:0] NEAR_RESET = 31'd256;
  localparam logic [30:0] FAR_RESET  = 31'd25600000;

  // One classified item on its way to the back end.
  typedef struct packed {
    req_t             kind;
    logic [1:0]       row;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [30:0]      radius;
  } cmd_t;

  // Frustum bounds as written through the configuration port.
  typedef struct packed {
    logic [30:0]      near_dist;
    logic [30:0]      far_dist;
    logic [3:0][53:0] plane;
  } frustum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EVAL,
    ST_DONE
  } seq_state_t;

endpackage

/* rtl/fcsb_channels.sv */
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
interface fcsb_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         row_select;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic [30:0]        sphere_radius;

  modport source(output valid, req_type, row_select, first_x, first_y, first_z,
                 second_x, second_y, second_z, sphere_radius, input ready);
  modport sink(input valid, req_type, row_select, first_x, first_y, first_z,
               second_x, second_y, second_z, sphere_radius, output ready);
endinterface

interface fcsb_res_if;
  logic valid;
  logic ready;
  logic culled;

  modport source(output valid, culled, input ready);
  modport sink(input valid, culled, output ready);
endinterface

/* rtl/fcsb_front.sv */
// Front end: registers incoming items and drops those that do nothing.
`timescale 1ns / 1ps
module fcsb_front (
  input  logic           clk,
  input  logic           rst,
  fcsb_req_if.sink       req,
  output fcsb_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready
);

  logic keep;

  assign req.ready = !cmd_valid || cmd_ready;

  // Loads to the unused row and the unused request code are dropped here.
  always_comb begin
    unique case (fcsb_pkg::req_t'(req.req_type))
      fcsb_pkg::REQ_LOAD:   keep = (req.row_select != 2'd3);
      fcsb_pkg::REQ_SPHERE: keep = 1'b1;
      fcsb_pkg::REQ_BOX:    keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.ready) begin
      cmd_valid <= req.valid && keep;
    end
  end

  // Payload holds while the queue is full.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd.kind   <= fcsb_pkg::req_t'(req.req_type);
      cmd.row    <= req.row_select;
      cmd.a      <= {req.first_z, req.first_y, req.first_x};
      cmd.b      <= {req.second_z, req.second_y, req.second_x};
      cmd.radius <= req.sphere_radius;
    end
  end

endmodule

/* rtl/fcsb_queue.sv */
// Small FIFO between the front end and the back end.
`timescale 1ns / 1ps
module fcsb_queue #(
  parameter int DEPTH = fcsb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fcsb_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fcsb_pkg::cmd_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  fcsb_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/fcsb_back.sv */
// Back end: matrix store and the shared transform and plane-test sequencer.
`timescale 1ns / 1ps
module fcsb_back (
  input  logic               clk,
  input  logic               rst,
  input  fcsb_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fcsb_pkg::frustum_t fr,
  fcsb_res_if.source         res
);

  fcsb_pkg::seq_state_t state;
  fcsb_pkg::seq_state_t state_next;

  fcsb_pkg::cmd_t      cur;
  logic [31:0]         mat [fcsb_pkg::ROW_COUNT][4];
  logic [2:0]          op;
  logic [2:0]          corner;
  logic [2:0][31:0]    v;
  logic signed [63:0]  prod [3];
  logic [3:0]          side;
  logic [5:0]          and_flags;
  logic                verdict;
  logic                out_valid;
  logic                out_culled;

  logic                is_sphere;
  logic                row_op;
  logic [1:0]          pl_idx;
  logic [2:0][31:0]    point;
  logic [2:0][31:0]    mul_a;
  logic [2:0][31:0]    mul_b;
  logic signed [51:0]  row_sum;
  logic [31:0]         row_sat;
  logic signed [53:0]  dot;
  logic signed [53:0]  r24;
  logic [30:0]         eff_radius;
  logic signed [33:0]  depth;
  logic signed [33:0]  near_lim;
  logic signed [33:0]  far_lim;
  logic [5:0]          flags;
  logic                out_free;
  logic                last_corner;

  assign is_sphere  = (cur.kind == fcsb_pkg::REQ_SPHERE);
  assign row_op     = (op <= 3'(fcsb_pkg::LAST_ROW_OP));
  assign pl_idx     = 2'(op - 3'(fcsb_pkg::LAST_ROW_OP + 1));
  assign eff_radius = is_sphere ? cur.radius : '0;
  assign out_free   = !out_valid || res.ready;
  assign last_corner = (corner == 3'd7);

  // Corner bit c picks the maximum for axis c.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      point[c] = corner[c] ? cur.b[c] : cur.a[c];
      if (row_op) begin
        mul_a[c] = mat[op[1:0]][c];
        mul_b[c] = point[c];
      end else begin
        mul_a[c] = v[c];
        mul_b[c] = 32'($signed(fr.plane[pl_idx][c*fcsb_pkg::NORMAL_W +: fcsb_pkg::NORMAL_W]));
      end
    end
  end

  // Row sum with floor-shifted products, saturated to 32 bits.
  always_comb begin
    row_sum = $signed(52'($signed(mat[op[1:0]][3])));
    for (int c = 0; c < 3; c++) begin
      row_sum = row_sum + 52'(prod[c] >>> 16);
    end
    if (row_sum > 52'sd2147483647) begin
      row_sat = 32'h7fffffff;
    end else if (row_sum < -52'sd2147483648) begin
      row_sat = 32'h80000000;
    end else begin
      row_sat = row_sum[31:0];
    end
  end

  // Plane distance in Q.24 against the radius scaled to Q.24.
  always_comb begin
    dot = '0;
    for (int c = 0; c < 3; c++) begin
      dot = dot + 54'(prod[c]);
    end
    r24 = $signed({7'd0, eff_radius, 16'd0});
  end

  // Near and far bounds on the negated depth.
  always_comb begin
    depth    = -34'($signed(v[2]));
    near_lim = $signed({3'd0, fr.near_dist}) - $signed({3'd0, eff_radius});
    far_lim  = $signed({3'd0, fr.far_dist}) + $signed({3'd0, eff_radius});
    flags    = {depth > far_lim, depth < near_lim, side};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fcsb_pkg::ST_IDLE: begin
        if (cmd_valid && cmd.kind != fcsb_pkg::REQ_LOAD) begin
          state_next = fcsb_pkg::ST_MUL;
        end
      end
      fcsb_pkg::ST_MUL: state_next = fcsb_pkg::ST_ACC;
      fcsb_pkg::ST_ACC: begin
        state_next = (op == 3'(fcsb_pkg::LAST_OP)) ? fcsb_pkg::ST_EVAL : fcsb_pkg::ST_MUL;
      end
      fcsb_pkg::ST_EVAL: begin
        if (is_sphere || flags == '0 || last_corner) begin
          state_next = fcsb_pkg::ST_DONE;
        end else begin
          state_next = fcsb_pkg::ST_MUL;
        end
      end
      fcsb_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = fcsb_pkg::ST_IDLE;
        end
      end
      default: state_next = fcsb_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_ready = (state == fcsb_pkg::ST_IDLE);
  end

  assign res.valid  = out_valid;
  assign res.culled = out_culled;

  // The result register is loaded only when it is free, so a waiting item keeps its flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcsb_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fcsb_pkg::ST_DONE && out_free) begin
        out_valid  <= 1'b1;
        out_culled <= verdict;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      fcsb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cur       <= cmd;
          op        <= '0;
          corner    <= '0;
          and_flags <= '1;
          if (cmd.kind == fcsb_pkg::REQ_LOAD) begin
            for (int c = 0; c < 3; c++) begin
              mat[cmd.row][c] <= cmd.a[c];
            end
            mat[cmd.row][3] <= cmd.b[0];
          end
        end
      end
      fcsb_pkg::ST_MUL: begin
        for (int c = 0; c < 3; c++) begin
          prod[c] <= 64'($signed(mul_a[c]) * $signed(mul_b[c]));
        end
      end
      fcsb_pkg::ST_ACC: begin
        if (row_op) begin
          v[op[1:0]] <= row_sat;
        end else begin
          side[pl_idx] <= (dot > r24);
        end
        if (op != 3'(fcsb_pkg::LAST_OP)) begin
          op <= op + 1'b1;
        end
      end
      fcsb_pkg::ST_EVAL: begin
        op     <= '0;
        corner <= corner + 1'b1;
        and_flags <= and_flags & flags;
        if (is_sphere) begin
          verdict <= (flags != '0);
        end else if (flags == '0) begin
          verdict <= 1'b0;
        end else begin
          verdict <= ((and_flags & flags) != '0);
        end
      end
      default: begin
      end
    endcase
  end

  a_op_range : assert property (@(posedge clk) disable iff (rst)
    state == fcsb_pkg::ST_MUL |-> op <= 3'(fcsb_pkg::LAST_OP))
    else $error("operation step out of range");

  a_sphere_one_pass : assert property (@(posedge clk) disable iff (rst)
    (state == fcsb_pkg::ST_EVAL && is_sphere) |=> state == fcsb_pkg::ST_DONE)
    else $error("sphere item ran more than one pass");

  a_no_load_result : assert property (@(posedge clk) disable iff (rst)
    state == fcsb_pkg::ST_DONE |-> cur.kind != fcsb_pkg::REQ_LOAD)
    else $error("load item reached the result stage");

endmodule

/* rtl/frustum_cull_sphere_box.sv */
// Top level of the sphere and box frustum culler.
// Load items pass the front register and queue and update one matrix row in the back end,
// with no result. Each sphere item and each box corner runs seven steps (three matrix rows,
// four side planes), each a multiply and an accumulate state, through three shared
// multipliers, then the evaluation state for the near, far and decision logic; a box stops at the
// first corner found inside all bounds or after its eighth corner. The queue lets new items
// enter while the back end is busy. A test must not read a matrix row that was never loaded.
`timescale 1ns / 1ps
module frustum_cull_sphere_box #(
  parameter int QUEUE_DEPTH = fcsb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  fcsb_req_if.sink    in_item,
  fcsb_res_if.source  result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [53:0] cfg_data
);

  fcsb_pkg::frustum_t fr;
  fcsb_pkg::cmd_t     front_cmd;
  fcsb_pkg::cmd_t     back_cmd;
  logic               front_valid;
  logic               front_ready;
  logic               back_valid;
  logic               back_ready;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fr.near_dist <= fcsb_pkg::NEAR_RESET;
      fr.far_dist  <= fcsb_pkg::FAR_RESET;
      fr.plane     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        fcsb_pkg::REG_NEAR:   fr.near_dist <= cfg_data[30:0];
        fcsb_pkg::REG_FAR:    fr.far_dist  <= cfg_data[30:0];
        fcsb_pkg::REG_LEFT:   fr.plane[0]  <= cfg_data;
        fcsb_pkg::REG_TOP:    fr.plane[1]  <= cfg_data;
        fcsb_pkg::REG_RIGHT:  fr.plane[2]  <= cfg_data;
        fcsb_pkg::REG_BOTTOM: fr.plane[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fcsb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (in_item),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  fcsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  fcsb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .fr        (fr),
    .res       (result)
  );

endmodule
